// ===== sv/crcsh_pkg.sv =====
`timescale 1ns / 1ps

package crcsh_pkg;

  localparam int BYTES_PER_ITEM = 8;
  localparam int DATA_W         = 64;
  localparam int COUNT_W        = 4;
  localparam int CRC_W          = 32;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;

  typedef struct packed {
    logic [DATA_W-1:0]  data_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               is_last;
  } msg_item_t;

  typedef struct packed {
    logic      valid;
    msg_item_t item;
  } stage_t;

  // one byte, lsb first, reflected polynomial
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] r;
    r = crc ^ {{(CRC_W-8){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // whole item; bytes past the count are skipped, counts above eight act as eight
  function automatic logic [CRC_W-1:0] crc_item(input logic [CRC_W-1:0] crc,
                                                input logic [DATA_W-1:0] data,
                                                input logic [COUNT_W-1:0] count);
    logic [CRC_W-1:0] r;
    logic [7:0]       b;
    r = crc;
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      b = 8'(data >> (8 * i));
      if (int'(count) > i) begin
        r = crc_byte(r, b);
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/crcsh_msg_if.sv =====
`timescale 1ns / 1ps

interface crcsh_msg_if;
  import crcsh_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_bytes;
  logic [COUNT_W-1:0] byte_count;
  logic               is_last;

  modport source (output valid, data_bytes, byte_count, is_last, input ready);
  modport sink   (input valid, data_bytes, byte_count, is_last, output ready);
  modport monitor (input valid, ready, data_bytes, byte_count, is_last);
endinterface

// ===== sv/crcsh_crc_if.sv =====
`timescale 1ns / 1ps

interface crcsh_crc_if;
  import crcsh_pkg::*;

  logic             valid;
  logic             ready;
  logic [CRC_W-1:0] crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
  modport monitor (input valid, ready, crc_value);
endinterface

// ===== sv/crcsh_in_reg.sv =====
`timescale 1ns / 1ps

module crcsh_in_reg (
  input  logic                clk,
  input  logic                rst,
  crcsh_msg_if.sink           msg,
  input  logic                advance,
  output crcsh_pkg::stage_t   stg
);
  import crcsh_pkg::*;

  logic      valid;
  msg_item_t item;

  // slot is free when empty or when its item moves on this cycle
  assign msg.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (msg.ready) begin
      valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      item.data_bytes <= msg.data_bytes;
      item.byte_count <= msg.byte_count;
      item.is_last    <= msg.is_last;
    end
  end

  assign stg.valid = valid;
  assign stg.item  = item;
endmodule

// ===== sv/crcsh_core.sv =====
`timescale 1ns / 1ps

module crcsh_core (
  input  logic                clk,
  input  logic                rst,
  input  crcsh_pkg::stage_t   stg,
  output logic                advance,
  crcsh_crc_if.source         crc
);
  import crcsh_pkg::*;

  logic [CRC_W-1:0] remainder;
  logic [CRC_W-1:0] remainder_next;
  logic [CRC_W-1:0] crc_value;
  logic             out_valid;

  assign remainder_next = crc_item(remainder, stg.item.data_bytes, stg.item.byte_count);

  // a last item needs the result slot free or draining
  assign advance = stg.valid && (!stg.item.is_last || !out_valid || crc.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      // a new result replaces one that drains in the same cycle
      if (advance && stg.item.is_last) begin
        out_valid <= 1'b1;
      end else if (crc.ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (stg.item.is_last) begin
          remainder <= CRC_INIT;
        end else begin
          remainder <= remainder_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stg.item.is_last) begin
      crc_value <= remainder_next;
    end
  end

  assign crc.valid     = out_valid;
  assign crc.crc_value = crc_value;
endmodule

// ===== sv/crc32c_stream_hasher_unit.sv =====
`timescale 1ns / 1ps

// CRC-32C (Castagnoli, reflected polynomial 0x82F63B78) over a byte stream.
// Each transfer on msg carries up to eight bytes, first byte in bits 7..0,
// with byte_count valid low-order bytes (counts above eight act as eight)
// and is_last marking the end of a message. The remainder starts at
// 0xFFFFFFFF; on the last transfer of a message one transfer goes out on
// crc with the remainder as is (no final inversion), and the next message
// starts fresh. An empty message yields 0xFFFFFFFF; transfers without
// is_last produce nothing. Throughput is one transfer per clock unless a
// result waits on crc: the eight-byte remainder update sits between the
// input register and the remainder register. A last input transfer passes
// through the input register and then the result register to crc valid. A
// result waiting on crc holds the next last item in the input register,
// which then blocks msg; items ahead of that last item keep flowing.
// msg.ready follows crc.ready combinationally.
module crc32c_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  crcsh_msg_if.sink   msg,
  crcsh_crc_if.source crc
);
  import crcsh_pkg::*;

  stage_t stg;
  logic   advance;

  // input register: decouples the source from the update loop
  crcsh_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .msg     (msg),
    .advance (advance),
    .stg     (stg)
  );

  // remainder update, remainder register and result register
  crcsh_core u_core (
    .clk     (clk),
    .rst     (rst),
    .stg     (stg),
    .advance (advance),
    .crc     (crc)
  );
endmodule

// ===== sv/crcsh_checker.sv =====
`timescale 1ns / 1ps

module crcsh_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      msg_valid,
  input logic                      msg_ready,
  input logic                      msg_is_last,
  input logic                      crc_valid,
  input logic                      crc_ready,
  input logic [crcsh_pkg::CRC_W-1:0] crc_value
);

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    crc_valid && !crc_ready |=> crc_valid && $stable(crc_value))
    else $error("crc result changed while stalled");

  // a fresh result follows a last transfer through the input and result registers
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(crc_valid) |-> $past(msg_valid && msg_ready && msg_is_last, 2))
    else $error("result without a matching last transfer");

  // input never blocked while the result side can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !crc_valid || crc_ready |-> msg_ready)
    else $error("msg stalled with free result slot");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !crc_valid)
    else $error("crc valid after reset");
endmodule

bind crc32c_stream_hasher_unit crcsh_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .msg_valid   (msg.valid),
  .msg_ready   (msg.ready),
  .msg_is_last (msg.is_last),
  .crc_valid   (crc.valid),
  .crc_ready   (crc.ready),
  .crc_value   (crc.crc_value)
);

// ===== test/crc32c_stream_hasher_unit_tb.sv =====
`timescale 1ns / 1ps

module crc32c_stream_hasher_unit_tb;
  import crcsh_pkg::*;

  // reflected castagnoli polynomial and seed, kept local to the testbench
  localparam logic [CRC_W-1:0] SEED_REMAINDER = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CASTAGNOLI_REFL = 32'h82F6_3B78;
  localparam int RANDOM_ITEMS = 1300;

  // tracks the running remainder of the message in flight and the queue
  // of crc values the block still owes
  class crc_scoreboard;
    logic [CRC_W-1:0] remainder;
    logic [CRC_W-1:0] owed_crcs[$];
    int mismatches;
    int transfers_in;
    int crcs_checked;

    function new();
      remainder = SEED_REMAINDER;
      mismatches = 0;
      transfers_in = 0;
      crcs_checked = 0;
    endfunction

    // bit-serial update, lsb of the first byte first
    function logic [CRC_W-1:0] absorb(logic [CRC_W-1:0] rem, logic [DATA_W-1:0] data,
                                      logic [COUNT_W-1:0] count);
      int nbytes;
      logic fb;
      nbytes = (count > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(count);
      for (int i = 0; i < 8 * nbytes; i++) begin
        fb = rem[0] ^ data[i];
        rem = rem >> 1;
        if (fb) begin
          rem = rem ^ CASTAGNOLI_REFL;
        end
      end
      return rem;
    endfunction

    function void note_transfer(logic [DATA_W-1:0] data, logic [COUNT_W-1:0] count,
                                logic last);
      transfers_in++;
      remainder = absorb(remainder, data, count);
      if (last) begin
        owed_crcs.push_back(remainder);
        remainder = SEED_REMAINDER;
      end
    endfunction

    function void check_crc(logic [CRC_W-1:0] actual);
      logic [CRC_W-1:0] want;
      if (owed_crcs.size() == 0) begin
        $error("crc_value: no result expected, actual %08h", actual);
        mismatches++;
      end else begin
        want = owed_crcs.pop_front();
        crcs_checked++;
        if (want !== actual) begin
          $error("crc_value mismatch: expected %08h actual %08h", want, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idling_on;
  int   items_sent;
  int   messages_sent;

  crcsh_msg_if msg_bus();
  crcsh_crc_if crc_bus();

  crc_scoreboard sb;

  crc32c_stream_hasher_unit DUT (
    .clk(clk),
    .rst(rst),
    .msg(msg_bus),
    .crc(crc_bus)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  // full words dominate, partial and oversized counts mixed in
  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return COUNT_W'(8);
    end else if (r < 85) begin
      return COUNT_W'($urandom_range(0, 7));
    end
    return COUNT_W'($urandom_range(9, 15));
  endfunction

  // transfer monitor: both sides sampled at the edge where they are accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (crc_bus.valid && crc_bus.ready) begin
        sb.check_crc(crc_bus.crc_value);
      end
      if (msg_bus.valid && msg_bus.ready) begin
        sb.note_transfer(msg_bus.data_bytes, msg_bus.byte_count, msg_bus.is_last);
      end
    end
  end

  // result side backpressure: runs of ready, stalls of random length
  initial begin
    int  span;
    bit  level;
    span = 0;
    level = 1'b0;
    crc_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        if (!idling_on) begin
          level = 1'b1;
          span = 1;
        end else if ($urandom_range(0, 2) != 0) begin
          level = 1'b1;
          span = $urandom_range(1, 12);
        end else begin
          level = 1'b0;
          span = pick_gap() + 1;
        end
      end
      crc_bus.ready <= level;
      span--;
    end
  end

  // one transfer on msg; valid is only lowered when a gap really follows
  task automatic send_item(logic [DATA_W-1:0] data, logic [COUNT_W-1:0] count,
                           logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      msg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_bus.valid      <= 1'b1;
    msg_bus.data_bytes <= data;
    msg_bus.byte_count <= count;
    msg_bus.is_last    <= last;
    do begin
      @(posedge clk);
    end while (!(msg_bus.valid && msg_bus.ready));
    items_sent++;
    if (last) begin
      messages_sent++;
    end
  endtask

  task automatic send_random_message(int n_items);
    for (int i = 0; i < n_items; i++) begin
      send_item({$urandom(), $urandom()}, pick_count(), i == n_items - 1);
    end
  endtask

  initial begin
    int r;
    int n;
    sb = new();
    idling_on = 1'b1;
    items_sent = 0;
    messages_sent = 0;
    rst <= 1'b1;
    msg_bus.valid      <= 1'b0;
    msg_bus.data_bytes <= '0;
    msg_bus.byte_count <= '0;
    msg_bus.is_last    <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message right after reset, must give the seed back
    send_item('0, COUNT_W'(0), 1'b1);
    // empty transfers ahead of a last one change nothing
    send_item({DATA_W{1'b1}}, COUNT_W'(0), 1'b0);
    send_item({DATA_W{1'b1}}, COUNT_W'(0), 1'b1);
    // standard check string "123456789" split as eight bytes plus one
    send_item(64'h3837_3635_3433_3231, COUNT_W'(8), 1'b0);
    send_item(64'hFFFF_FFFF_FFFF_FF39, COUNT_W'(1), 1'b1);
    // extremes of the data word, full and single-item messages
    send_item({DATA_W{1'b1}}, COUNT_W'(8), 1'b1);
    send_item('0, COUNT_W'(8), 1'b1);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, COUNT_W'(8), 1'b0);
    send_item(64'h5555_5555_5555_5555, COUNT_W'(8), 1'b1);
    // every partial count, junk above the valid bytes must be ignored
    for (int c = 1; c < 8; c++) begin
      send_item({$urandom(), $urandom()}, COUNT_W'(c), c == 7);
    end
    // oversized counts act as eight, including the all-ones count
    send_item(64'h0123_4567_89AB_CDEF, COUNT_W'(9), 1'b0);
    send_item(64'hFEDC_BA98_7654_3210, COUNT_W'(15), 1'b1);
    send_item(64'h0123_4567_89AB_CDEF, COUNT_W'(12), 1'b1);
    // empty last after real bytes closes the message as is
    send_item({$urandom(), $urandom()}, COUNT_W'(8), 1'b0);
    send_item('0, COUNT_W'(0), 1'b1);

    // random messages; a stretch in the middle runs with no idling at all
    while (items_sent < RANDOM_ITEMS) begin
      idling_on = !(items_sent > 500 && items_sent < 800);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = $urandom_range(1, 4);
      end else if (r < 95) begin
        n = $urandom_range(5, 16);
      end else begin
        n = $urandom_range(17, 60);
      end
      send_random_message(n);
    end
    idling_on = 1'b1;
    msg_bus.valid <= 1'b0;

    // drain owed results, then a few cycles for anything unexpected
    while (sb.owed_crcs.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("%0d messages in %0d input transfers, %0d crc results compared",
             messages_sent, sb.transfers_in, sb.crcs_checked);
    $display("counts 0 to 15, empty and multi-word messages, random stalls on both sides");
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
